@@ hw/rtl/umsk_pkg.sv @@
// ----------------------------------------------------------------------------
// umsk_pkg
// shared widths, register indexes, command and status types and the
// blur coefficient table of the unsharp mask
// ----------------------------------------------------------------------------
package umsk_pkg;

   localparam int UMSK_MAX_WIDTH      = 1024;
   localparam int UMSK_COEF_FRAC_BITS = 16;

   localparam int PIX_W       = 8;
   localparam int ROW_W       = 12;
   localparam int OUT_COL_W   = 10;
   localparam int N_W         = 22;
   localparam int GAIN_W      = 4;
   localparam int IMG_W_W     = 11;
   localparam int IMG_H_W     = 13;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 13;

   localparam int PIX_MAX     = 255;
   localparam int MIN_DIM     = 3;
   localparam int MAX_HEIGHT  = 4096;
   localparam int IN_ROW_MAX  = 4095;

   localparam logic                 RST_FILTER_MODE  = 1'b0;
   localparam logic                 RST_RADIUS       = 1'b1;
   localparam logic [GAIN_W-1:0]    RST_GAIN         = 4'd1;
   localparam logic [IMG_W_W-1:0]   RST_IMAGE_WIDTH  = 11'd640;
   localparam logic [IMG_H_W-1:0]   RST_IMAGE_HEIGHT = 13'd480;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FILTER_MODE  = 3'd0,
      CSR_RADIUS       = 3'd1,
      CSR_GAIN         = 3'd2,
      CSR_IMAGE_WIDTH  = 3'd3,
      CSR_IMAGE_HEIGHT = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      TERM_CENTRE = 2'd0,
      TERM_EDGE   = 2'd1,
      TERM_CORNER = 2'd2
   } mac_term_type;

   typedef enum logic [2:0] {
      COEF_BOX1     = 3'd0,
      COEF_BOX3     = 3'd1,
      COEF_GAUSS_C  = 3'd2,
      COEF_GAUSS_E  = 3'd3,
      COEF_GAUSS_K  = 3'd4
   } coef_idx_type;

   localparam int COEF24_BITS = 24;
   localparam int COEF_MAX_W  = COEF24_BITS + 1;

   localparam logic [COEF_MAX_W-1:0] COEF24 [5] = '{
      25'd16777216, 25'd1864135, 25'd2670177, 25'd1619541, 25'd982303
   };

   // round half-up from 24 fraction bits to frac_bits
   function automatic logic [COEF_MAX_W-1:0] coef_value(input coef_idx_type idx,
                                                         input int frac_bits);
      logic [COEF_MAX_W:0] c;
      int                  s;
      c = {1'b0, COEF24[idx]};
      s = COEF24_BITS - frac_bits;
      if (s == 0) begin
         return c[COEF_MAX_W-1:0];
      end
      c = c + ((COEF_MAX_W+1)'(1) << (s - 1));
      c = c >> s;
      return c[COEF_MAX_W-1:0];
   endfunction

   typedef struct packed {
      logic         accept;
      logic         shift;
      logic         mac_step;
      mac_term_type mac_term;
      logic         gain_step;
      logic         out_load;
      logic         div_start;
      logic         div_step;
   } umsk_cmd_type;

   typedef struct packed {
      logic has_result;
      logic geom_pending;
      logic div_last;
      logic rsp_free;
   } umsk_status_type;

endpackage

@@ hw/rtl/umsk_req_if.sv @@
// ----------------------------------------------------------------------------
// umsk_req_if
// input channel of the unsharp mask: pixel or flush item
// ----------------------------------------------------------------------------
interface umsk_req_if import umsk_pkg::*;;
   logic             valid;
   logic             ready;
   logic             req_type;
   logic [PIX_W-1:0] pixel_in;

   modport source (output valid, output req_type, output pixel_in, input ready);
   modport sink   (input valid, input req_type, input pixel_in, output ready);
endinterface

@@ hw/rtl/umsk_rsp_if.sv @@
// ----------------------------------------------------------------------------
// umsk_rsp_if
// result channel of the unsharp mask: sharpened pixel and its position
// ----------------------------------------------------------------------------
interface umsk_rsp_if import umsk_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic [PIX_W-1:0]     pixel_out;
   logic [ROW_W-1:0]     out_row;
   logic [OUT_COL_W-1:0] out_col;
   logic                 frame_last;

   modport source (output valid, output pixel_out, output out_row, output out_col,
                   output frame_last, input ready);
   modport sink   (input valid, input pixel_out, input out_row, input out_col,
                   input frame_last, output ready);
endinterface

@@ hw/rtl/unsharp_mask_3x3.sv @@
// ----------------------------------------------------------------------------
// unsharp_mask_3x3
// streaming 3x3 unsharp mask on 8-bit grey pixels in raster order
// ----------------------------------------------------------------------------
// req_chan takes pixel items (req_type 0) and flush items (req_type 1, seen
// as a zero pixel); rsp_chan gives the sharpened pixel with its row, column
// and a frame_last flag. Results lag the input by image_width+1 items, so
// image_width+1 flush items after the last pixel drain the frame.
// csr_* writes filter_mode, radius, gain, image_width and image_height by
// index; write only while no item is in flight.
// An item that gives no result is accepted and shifted in; one that gives a
// result also runs the three-step blur accumulation on one shared multiplier
// plus gain and rounding stages before the result register is loaded.
// A width or height write starts a recompute of the output position (one
// quotient bit a cycle), during which req_chan.ready is low.
// Reset clears counters and window and loads the configuration defaults; the
// line store is not cleared. While rsp_chan stalls, the finished pixel waits
// in the output register and the next result is still made; later items wait.
// ----------------------------------------------------------------------------
module unsharp_mask_3x3 import umsk_pkg::*; #(
   parameter int MAX_WIDTH      = UMSK_MAX_WIDTH,
   parameter int COEF_FRAC_BITS = UMSK_COEF_FRAC_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   umsk_req_if.sink               req_chan,
   umsk_rsp_if.source             rsp_chan,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wr_data
);

   umsk_cmd_type    cmd;
   umsk_status_type status;
   logic            req_ready;

   umsk_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   umsk_dpath #(
      .MAX_WIDTH      (MAX_WIDTH),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_type    (req_chan.req_type),
      .pixel_in    (req_chan.pixel_in),
      .rsp_valid   (rsp_chan.valid),
      .rsp_ready   (rsp_chan.ready),
      .pixel_out   (rsp_chan.pixel_out),
      .out_row     (rsp_chan.out_row),
      .out_col     (rsp_chan.out_col),
      .frame_last  (rsp_chan.frame_last),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .status      (status)
   );

   assign req_chan.ready = req_ready;

endmodule

@@ hw/rtl/umsk_ctrl.sv @@
// ----------------------------------------------------------------------------
// umsk_ctrl
// sequencer: item intake, line store update, blur accumulation over three
// terms, gain stage, result load and position recompute after a geometry write
// ----------------------------------------------------------------------------
module umsk_ctrl import umsk_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  umsk_status_type status,
   output umsk_cmd_type    cmd
);

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_SHIFT = 8'b0000_0010,
      ST_MAC0  = 8'b0000_0100,
      ST_MAC1  = 8'b0000_1000,
      ST_MAC2  = 8'b0001_0000,
      ST_GAIN  = 8'b0010_0000,
      ST_FINAL = 8'b0100_0000,
      ST_DIV   = 8'b1000_0000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.mac_term = TERM_CENTRE;
      req_ready    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = !status.geom_pending && !reset;
            if (status.geom_pending) begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV;
            end else if (req_valid && !reset) begin
               cmd.accept = 1'b1;
               state_in   = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            cmd.shift = 1'b1;
            state_in  = status.has_result ? ST_MAC0 : ST_IDLE;
         end
         ST_MAC0: begin
            cmd.mac_step = 1'b1;
            cmd.mac_term = TERM_CENTRE;
            state_in     = ST_MAC1;
         end
         ST_MAC1: begin
            cmd.mac_step = 1'b1;
            cmd.mac_term = TERM_EDGE;
            state_in     = ST_MAC2;
         end
         ST_MAC2: begin
            cmd.mac_step = 1'b1;
            cmd.mac_term = TERM_CORNER;
            state_in     = ST_GAIN;
         end
         ST_GAIN: begin
            cmd.gain_step = 1'b1;
            state_in      = ST_FINAL;
         end
         ST_FINAL: begin
            if (status.rsp_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ hw/rtl/umsk_dpath.sv @@
// ----------------------------------------------------------------------------
// umsk_dpath
// configuration registers, two-row line store, 3x3 window, position
// counters, shared blur multiplier, gain and rounding stages, result register
// and a restoring divider that rebuilds the output position
// ----------------------------------------------------------------------------
module umsk_dpath import umsk_pkg::*; #(
   parameter int MAX_WIDTH      = UMSK_MAX_WIDTH,
   parameter int COEF_FRAC_BITS = UMSK_COEF_FRAC_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_type,
   input  logic [PIX_W-1:0]       pixel_in,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [PIX_W-1:0]       pixel_out,
   output logic [ROW_W-1:0]       out_row,
   output logic [OUT_COL_W-1:0]   out_col,
   output logic                   frame_last,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wr_data,
   input  umsk_cmd_type           cmd,
   output umsk_status_type        status
);

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int WEFF_W = ($clog2(MAX_WIDTH + 1) > IMG_W_W) ? $clog2(MAX_WIDTH + 1) : IMG_W_W;
   localparam int PROD_W = WEFF_W + IMG_H_W;
   localparam int CMP_W  = (PROD_W > N_W + 1) ? PROD_W : N_W + 1;
   localparam int DIVC_W = $clog2(N_W);
   localparam int SUM_W  = 12;
   localparam int PART_W = 10;
   localparam int COEF_W = COEF_FRAC_BITS + 1;
   localparam int ACC_W  = COEF_FRAC_BITS + 10;
   localparam int BASE_W = GAIN_W + 1 + PIX_W;
   localparam int POS_W  = BASE_W + COEF_FRAC_BITS;
   localparam int NEG_W  = ACC_W + GAIN_W;
   localparam int D_W    = NEG_W + 1;
   localparam int Y_W    = D_W - COEF_FRAC_BITS;

   localparam logic [COEF_W-1:0] C_BOX1 = COEF_W'(coef_value(COEF_BOX1, COEF_FRAC_BITS));
   localparam logic [COEF_W-1:0] C_BOX3 = COEF_W'(coef_value(COEF_BOX3, COEF_FRAC_BITS));
   localparam logic [COEF_W-1:0] C_GC   = COEF_W'(coef_value(COEF_GAUSS_C, COEF_FRAC_BITS));
   localparam logic [COEF_W-1:0] C_GE   = COEF_W'(coef_value(COEF_GAUSS_E, COEF_FRAC_BITS));
   localparam logic [COEF_W-1:0] C_GK   = COEF_W'(coef_value(COEF_GAUSS_K, COEF_FRAC_BITS));

   // configuration
   logic               filter_mode_ff;
   logic               radius_ff;
   logic [GAIN_W-1:0]  gain_ff;
   logic [IMG_W_W-1:0] image_width_ff;
   logic [IMG_H_W-1:0] image_height_ff;
   logic               geom_pending_ff;
   logic               geom_pending_in;
   logic [WEFF_W-1:0]  w_eff;
   logic [IMG_H_W-1:0] h_eff;
   logic [PROD_W-1:0]  frame_size_ff;

   // line store and window
   logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
   logic [2*PIX_W-1:0] line_rd_ff;
   logic [PIX_W-1:0]   pix_ff;
   logic [PIX_W-1:0]   win_ff [3][3];
   logic [PIX_W-1:0]   centre;

   // counters
   logic [ROW_W-1:0]   in_row_ff, in_row_in;
   logic [COL_W-1:0]   in_col_ff, in_col_in;
   logic [N_W-1:0]     n_ff, n_in;
   logic [N_W-1:0]     orow_ff, orow_in;
   logic [COL_W-1:0]   ocol_ff, ocol_in;
   logic [WEFF_W:0]    col_p1;
   logic [WEFF_W:0]    ocol_p1;
   logic [N_W:0]       n_p1;
   logic               col_wrap;
   logic               ocol_wrap;
   logic               frame_end;
   logic               border;
   logic               has_result;

   // item info
   logic [ROW_W-1:0]     info_row_ff;
   logic [OUT_COL_W-1:0] info_col_ff;
   logic                 info_last_ff;
   logic                 info_border_ff;

   // arithmetic
   logic [PART_W-1:0]       edge_sum;
   logic [PART_W-1:0]       corner_sum;
   logic [SUM_W-1:0]        sum9;
   logic [COEF_W-1:0]       mac_coef;
   logic [SUM_W-1:0]        mac_sum;
   logic [COEF_W+SUM_W-1:0] mac_prod;
   logic [ACC_W-1:0]        acc_ff, acc_in;
   logic [BASE_W-1:0]       pos_base;
   logic [BASE_W-1:0]       pos_prod;
   logic [POS_W-1:0]        pos_ff;
   logic [NEG_W-1:0]        neg_ff;
   logic [D_W-1:0]          diff_rnd;
   logic [Y_W-1:0]          y_full;
   logic [PIX_W-1:0]        sharp;
   logic [PIX_W-1:0]        result;

   // divider
   logic [N_W-1:0]    div_q_ff, div_q_next;
   logic [WEFF_W-1:0] div_rem_ff, div_rem_next;
   logic [WEFF_W-1:0] div_d_ff;
   logic [DIVC_W-1:0] div_cnt_ff;
   logic [WEFF_W:0]   div_trial;
   logic              div_ge;
   logic              div_last;

   // result register
   logic                 rsp_valid_ff;
   logic [PIX_W-1:0]     rsp_pix_ff;
   logic [ROW_W-1:0]     rsp_row_ff;
   logic [OUT_COL_W-1:0] rsp_col_ff;
   logic                 rsp_last_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         filter_mode_ff  <= RST_FILTER_MODE;
         radius_ff       <= RST_RADIUS;
         gain_ff         <= RST_GAIN;
         image_width_ff  <= RST_IMAGE_WIDTH;
         image_height_ff <= RST_IMAGE_HEIGHT;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_FILTER_MODE:  filter_mode_ff  <= csr_wr_data[0];
            CSR_RADIUS:       radius_ff       <= csr_wr_data[0];
            CSR_GAIN:         gain_ff         <= csr_wr_data[GAIN_W-1:0];
            CSR_IMAGE_WIDTH:  image_width_ff  <= csr_wr_data[IMG_W_W-1:0];
            CSR_IMAGE_HEIGHT: image_height_ff <= csr_wr_data[IMG_H_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      geom_pending_in = geom_pending_ff;
      if (cmd.div_start) begin
         geom_pending_in = 1'b0;
      end
      if (csr_wr_en && (csr_index == CSR_IMAGE_WIDTH || csr_index == CSR_IMAGE_HEIGHT)) begin
         geom_pending_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         geom_pending_ff <= 1'b0;
      end else begin
         geom_pending_ff <= geom_pending_in;
      end
   end

   // effective geometry
   always_comb begin
      if (image_width_ff < IMG_W_W'(MIN_DIM)) begin
         w_eff = WEFF_W'(MIN_DIM);
      end else if (WEFF_W'(image_width_ff) > WEFF_W'(MAX_WIDTH)) begin
         w_eff = WEFF_W'(MAX_WIDTH);
      end else begin
         w_eff = WEFF_W'(image_width_ff);
      end
      if (image_height_ff < IMG_H_W'(MIN_DIM)) begin
         h_eff = IMG_H_W'(MIN_DIM);
      end else if (image_height_ff > IMG_H_W'(MAX_HEIGHT)) begin
         h_eff = IMG_H_W'(MAX_HEIGHT);
      end else begin
         h_eff = image_height_ff;
      end
   end

   always_ff @(posedge clock) begin
      frame_size_ff <= PROD_W'(w_eff) * PROD_W'(h_eff);
   end

   // intake and line store
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         pix_ff     <= req_type ? '0 : pixel_in;
         line_rd_ff <= line_mem[in_col_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.shift) begin
         line_mem[in_col_ff] <= {line_rd_ff[PIX_W-1:0], pix_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               win_ff[r][c] <= '0;
            end
         end
      end else if (cmd.shift) begin
         for (int r = 0; r < 3; r++) begin
            win_ff[r][0] <= win_ff[r][1];
            win_ff[r][1] <= win_ff[r][2];
         end
         win_ff[0][2] <= line_rd_ff[2*PIX_W-1:PIX_W];
         win_ff[1][2] <= line_rd_ff[PIX_W-1:0];
         win_ff[2][2] <= pix_ff;
      end
   end

   assign centre = win_ff[1][1];

   // position counters
   always_comb begin
      col_p1     = (WEFF_W+1)'(in_col_ff) + (WEFF_W+1)'(1);
      col_wrap   = col_p1 >= {1'b0, w_eff};
      ocol_p1    = (WEFF_W+1)'(ocol_ff) + (WEFF_W+1)'(1);
      ocol_wrap  = ocol_p1 >= {1'b0, w_eff};
      n_p1       = {1'b0, n_ff} + (N_W+1)'(1);
      frame_end  = CMP_W'(n_p1) >= CMP_W'(frame_size_ff);
      border     = (orow_ff == '0) || (orow_ff >= N_W'(h_eff) - N_W'(1)) || (ocol_ff == '0)
                   || (WEFF_W'(ocol_ff) == w_eff - WEFF_W'(1));
      has_result = (in_row_ff >= ROW_W'(2)) || (in_row_ff == ROW_W'(1) && in_col_ff != '0);

      in_row_in = in_row_ff;
      in_col_in = in_col_ff;
      n_in      = n_ff;
      orow_in   = orow_ff;
      ocol_in   = ocol_ff;
      if (cmd.shift) begin
         if (col_wrap) begin
            in_col_in = '0;
            in_row_in = (in_row_ff != ROW_W'(IN_ROW_MAX)) ? in_row_ff + ROW_W'(1) : in_row_ff;
         end else begin
            in_col_in = col_p1[COL_W-1:0];
         end
         if (has_result) begin
            if (frame_end) begin
               in_row_in = '0;
               in_col_in = '0;
               n_in      = '0;
               orow_in   = '0;
               ocol_in   = '0;
            end else begin
               n_in = n_p1[N_W-1:0];
               if (ocol_wrap) begin
                  ocol_in = '0;
                  orow_in = orow_ff + N_W'(1);
               end else begin
                  ocol_in = ocol_p1[COL_W-1:0];
               end
            end
         end
      end
      if (cmd.div_step && div_last) begin
         orow_in = div_q_next;
         ocol_in = div_rem_next[COL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_row_ff <= '0;
         in_col_ff <= '0;
         n_ff      <= '0;
         orow_ff   <= '0;
         ocol_ff   <= '0;
      end else begin
         in_row_ff <= in_row_in;
         in_col_ff <= in_col_in;
         n_ff      <= n_in;
         orow_ff   <= orow_in;
         ocol_ff   <= ocol_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.shift && has_result) begin
         info_row_ff    <= orow_ff[ROW_W-1:0];
         info_col_ff    <= OUT_COL_W'(ocol_ff);
         info_last_ff   <= frame_end;
         info_border_ff <= border;
      end
   end

   // blur accumulation, one term per step
   always_comb begin
      edge_sum   = PART_W'(win_ff[0][1]) + PART_W'(win_ff[1][0])
                 + PART_W'(win_ff[1][2]) + PART_W'(win_ff[2][1]);
      corner_sum = PART_W'(win_ff[0][0]) + PART_W'(win_ff[0][2])
                 + PART_W'(win_ff[2][0]) + PART_W'(win_ff[2][2]);
      sum9       = SUM_W'(edge_sum) + SUM_W'(corner_sum) + SUM_W'(centre);
      mac_coef   = '0;
      mac_sum    = '0;
      if (!radius_ff) begin
         if (cmd.mac_term == TERM_CENTRE) begin
            mac_coef = filter_mode_ff ? C_GC : C_BOX1;
            mac_sum  = SUM_W'(centre);
         end
      end else if (!filter_mode_ff) begin
         if (cmd.mac_term == TERM_CENTRE) begin
            mac_coef = C_BOX3;
            mac_sum  = sum9;
         end
      end else begin
         unique case (cmd.mac_term)
            TERM_CENTRE: begin
               mac_coef = C_GC;
               mac_sum  = SUM_W'(centre);
            end
            TERM_EDGE: begin
               mac_coef = C_GE;
               mac_sum  = SUM_W'(edge_sum);
            end
            TERM_CORNER: begin
               mac_coef = C_GK;
               mac_sum  = SUM_W'(corner_sum);
            end
            default: begin
            end
         endcase
      end
      mac_prod = (COEF_W+SUM_W)'(mac_coef) * (COEF_W+SUM_W)'(mac_sum);
      acc_in   = ((cmd.mac_term == TERM_CENTRE) ? '0 : acc_ff) + mac_prod[ACC_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.mac_step) begin
         acc_ff <= acc_in;
      end
   end

   // gain stage
   assign pos_base = BASE_W'(gain_ff) + BASE_W'(1);
   assign pos_prod = pos_base * BASE_W'(centre);

   always_ff @(posedge clock) begin
      if (cmd.gain_step) begin
         pos_ff <= {pos_prod, {COEF_FRAC_BITS{1'b0}}};
         neg_ff <= NEG_W'(gain_ff) * NEG_W'(acc_ff);
      end
   end

   // round and clamp
   always_comb begin
      diff_rnd = D_W'(pos_ff) - D_W'(neg_ff) + (D_W'(1) << (COEF_FRAC_BITS - 1));
      y_full   = diff_rnd[D_W-1:COEF_FRAC_BITS];
      if (D_W'(neg_ff) > D_W'(pos_ff)) begin
         sharp = '0;
      end else if (y_full > Y_W'(PIX_MAX)) begin
         sharp = PIX_W'(PIX_MAX);
      end else begin
         sharp = y_full[PIX_W-1:0];
      end
      result = info_border_ff ? centre : sharp;
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_pix_ff  <= result;
         rsp_row_ff  <= info_row_ff;
         rsp_col_ff  <= info_col_ff;
         rsp_last_ff <= info_last_ff;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign pixel_out  = rsp_pix_ff;
   assign out_row    = rsp_row_ff;
   assign out_col    = rsp_col_ff;
   assign frame_last = rsp_last_ff;

   // position recompute: pixel count divided by width, one bit a cycle
   always_comb begin
      div_trial    = {div_rem_ff, div_q_ff[N_W-1]};
      div_ge       = div_trial >= {1'b0, div_d_ff};
      div_rem_next = div_ge ? WEFF_W'(div_trial - {1'b0, div_d_ff}) : div_trial[WEFF_W-1:0];
      div_q_next   = {div_q_ff[N_W-2:0], div_ge};
      div_last     = div_cnt_ff == DIVC_W'(N_W - 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_cnt_ff <= '0;
      end else if (cmd.div_start) begin
         div_cnt_ff <= '0;
      end else if (cmd.div_step) begin
         div_cnt_ff <= div_cnt_ff + DIVC_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         div_q_ff   <= n_ff;
         div_rem_ff <= '0;
         div_d_ff   <= w_eff;
      end else if (cmd.div_step) begin
         div_q_ff   <= div_q_next;
         div_rem_ff <= div_rem_next;
      end
   end

   assign status.has_result   = has_result;
   assign status.geom_pending = geom_pending_ff;
   assign status.div_last     = div_last;
   assign status.rsp_free     = !rsp_valid_ff || rsp_ready;

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the streaming 3x3 unsharp mask: frames of random
// pixels and flush items under several kernel, gain and geometry settings,
// with random gaps on both channels and one long output stall; every result
// is compared field by field with a bit-exact fixed-point predictor
// ----------------------------------------------------------------------------
module testbench import umsk_pkg::*;;

   localparam int     HALF_PERIOD   = 6;
   localparam int     RESET_CYCLES  = 5;
   localparam int     SETTLE_CYCLES = 32;
   localparam int     HOLD_CYCLES   = 400;
   localparam int     LIMIT_CYCLES  = 1000000;
   localparam int     FRAC          = UMSK_COEF_FRAC_BITS;

   localparam longint KERNEL_BOX1    = 65536;
   localparam longint KERNEL_BOX3    = 7282;
   localparam longint KERNEL_GAUSS_C = 10430;
   localparam longint KERNEL_GAUSS_E = 6326;
   localparam longint KERNEL_GAUSS_K = 3837;

   localparam logic   REQ_PIXEL = 1'b0;
   localparam logic   REQ_FLUSH = 1'b1;

   typedef struct {
      logic [PIX_W-1:0]     pixel;
      logic [ROW_W-1:0]     row;
      logic [OUT_COL_W-1:0] col;
      logic                 last;
   } out_pixel_type;

   class unsharp_scoreboard;
      logic [PIX_W-1:0]   line_mem [2*UMSK_MAX_WIDTH];
      logic [PIX_W-1:0]   win [3][3];
      int unsigned        in_row;
      int unsigned        in_col;
      int unsigned        out_count;
      logic               gauss_on;
      logic               wide_kernel;
      logic [GAIN_W-1:0]  gain;
      logic [IMG_W_W-1:0] width_reg;
      logic [IMG_H_W-1:0] height_reg;
      out_pixel_type      expected_pixels [$];
      int unsigned        n_errors;

      function new();
         foreach (line_mem[i]) line_mem[i] = '0;
         foreach (win[r, c]) win[r][c] = '0;
         in_row      = 0;
         in_col      = 0;
         out_count   = 0;
         gauss_on    = RST_FILTER_MODE;
         wide_kernel = RST_RADIUS;
         gain        = RST_GAIN;
         width_reg   = RST_IMAGE_WIDTH;
         height_reg  = RST_IMAGE_HEIGHT;
         n_errors    = 0;
      endfunction

      function void set_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            CSR_FILTER_MODE:  gauss_on    = val[0];
            CSR_RADIUS:       wide_kernel = val[0];
            CSR_GAIN:         gain        = val[GAIN_W-1:0];
            CSR_IMAGE_WIDTH:  width_reg   = val[IMG_W_W-1:0];
            CSR_IMAGE_HEIGHT: height_reg  = val[IMG_H_W-1:0];
            default: ;
         endcase
      endfunction

      function int unsigned eff_width();
         if (width_reg < MIN_DIM) return MIN_DIM;
         if (width_reg > UMSK_MAX_WIDTH) return UMSK_MAX_WIDTH;
         return 32'(width_reg);
      endfunction

      function int unsigned eff_height();
         if (height_reg < MIN_DIM) return MIN_DIM;
         if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
         return 32'(height_reg);
      endfunction

      function int pending();
         return expected_pixels.size();
      endfunction

      function longint blur_sum();
         longint acc;
         int     d;
         acc = 0;
         if (!wide_kernel) begin
            return (gauss_on ? KERNEL_GAUSS_C : KERNEL_BOX1) * longint'(win[1][1]);
         end
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               d = (r != 1) + (c != 1);
               acc += (gauss_on ? (d == 0 ? KERNEL_GAUSS_C :
                                   d == 1 ? KERNEL_GAUSS_E : KERNEL_GAUSS_K)
                                : KERNEL_BOX3) * longint'(win[r][c]);
            end
         end
         return acc;
      endfunction

      function logic [PIX_W-1:0] sharpened_value(logic [PIX_W-1:0] centre);
         longint x;
         x = (((longint'(gain) + 1) * longint'(centre)) <<< FRAC)
             - longint'(gain) * blur_sum();
         if (x < 0) return '0;
         x = (x + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
         return (x > PIX_MAX) ? PIX_W'(PIX_MAX) : PIX_W'(x);
      endfunction

      // one accepted item: shift the line store and window, maybe emit a pixel
      function void take_item(logic kind, logic [PIX_W-1:0] pix);
         int unsigned      w, h, c, r, n;
         logic [PIX_W-1:0] p, a, b;
         bit               emits, border;
         out_pixel_type    e;
         w = eff_width();
         h = eff_height();
         p = (kind == REQ_FLUSH) ? '0 : pix;
         c = (in_col >= UMSK_MAX_WIDTH) ? 0 : in_col;
         r = in_row;
         a = line_mem[c];
         b = line_mem[UMSK_MAX_WIDTH + c];
         line_mem[UMSK_MAX_WIDTH + c] = a;
         line_mem[c] = p;
         for (int k = 0; k < 3; k++) begin
            win[k][0] = win[k][1];
            win[k][1] = win[k][2];
         end
         win[0][2] = b;
         win[1][2] = a;
         win[2][2] = p;
         emits = (r >= 2) || (r == 1 && c >= 1);
         if (c + 1 >= w) begin
            in_col = 0;
            if (r < IN_ROW_MAX) in_row = r + 1;
         end else begin
            in_col = c + 1;
         end
         if (!emits) return;
         n = out_count;
         border  = (n / w == 0) || (n / w >= h - 1) || (n % w == 0) || (n % w == w - 1);
         e.row   = ROW_W'(n / w);
         e.col   = OUT_COL_W'(n % w);
         e.last  = (n + 1 >= w * h);
         e.pixel = border ? win[1][1] : sharpened_value(win[1][1]);
         expected_pixels.push_back(e);
         if (e.last) begin
            in_row    = 0;
            in_col    = 0;
            out_count = 0;
         end else begin
            out_count = (n + 1) % (1 << N_W);
         end
      endfunction

      task report(string msg);
         n_errors++;
         $display("ERROR: %s", msg);
      endtask

      task check_result(out_pixel_type got);
         out_pixel_type e;
         if (expected_pixels.size() == 0) begin
            report($sformatf("unexpected item: pixel %0d row %0d col %0d last %0d",
                             got.pixel, got.row, got.col, got.last));
            return;
         end
         e = expected_pixels.pop_front();
         if (got.pixel !== e.pixel)
            report($sformatf("pixel at row %0d col %0d: got %0d, expected %0d",
                             e.row, e.col, got.pixel, e.pixel));
         if (got.row !== e.row)
            report($sformatf("row: got %0d, expected %0d", got.row, e.row));
         if (got.col !== e.col)
            report($sformatf("col at row %0d: got %0d, expected %0d", e.row, got.col, e.col));
         if (got.last !== e.last)
            report($sformatf("frame_last at row %0d col %0d: got %0d, expected %0d",
                             e.row, e.col, got.last, e.last));
      endtask
   endclass

   logic                   clock;
   logic                   reset;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wr_data;

   int unsigned            items_sent     = 0;
   int unsigned            hold_orders    = 0;
   int unsigned            cycle_count    = 0;
   int                     src_gap_pct    = 25;
   int                     sink_stall_pct = 78;

   unsharp_scoreboard      sb = new();

   umsk_req_if req_bus ();
   umsk_rsp_if rsp_bus ();

   unsharp_mask_3x3 i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #HALF_PERIOD clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // result side: checks, random stalls and the long hold-off
   initial begin : result_side
      int unsigned   hold_seen;
      int unsigned   hold_left;
      out_pixel_type got;
      hold_seen = 0;
      hold_left = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            got.pixel = rsp_bus.pixel_out;
            got.row   = rsp_bus.out_row;
            got.col   = rsp_bus.out_col;
            got.last  = rsp_bus.frame_last;
            sb.check_result(got);
         end
         if (hold_orders != hold_seen) begin
            hold_seen = hold_orders;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
         end
      end
   end

   function automatic logic [PIX_W-1:0] some_pixel();
      case ($urandom_range(7))
         0:       return '0;
         1:       return '1;
         default: return PIX_W'($urandom);
      endcase
   endfunction

   task automatic send_item(input logic kind, input logic [PIX_W-1:0] pix);
      if ($urandom_range(99) < src_gap_pct) begin
         req_bus.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < src_gap_pct);
      end
      req_bus.valid    <= 1'b1;
      req_bus.req_type <= kind;
      req_bus.pixel_in <= pix;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      sb.take_item(kind, pix);
      items_sent++;
   endtask

   task automatic send_random(input int unsigned flush_pct);
      if ($urandom_range(99) < flush_pct) send_item(REQ_FLUSH, PIX_W'($urandom));
      else send_item(REQ_PIXEL, some_pixel());
   endtask

   // a whole frame, then width+1 items to drain it
   task automatic send_frame(input int unsigned flush_pct, input int unsigned drain_flush_pct);
      int unsigned n_frame, n_drain;
      n_frame = sb.eff_width() * sb.eff_height();
      n_drain = sb.eff_width() + 1;
      repeat (n_frame) send_random(flush_pct);
      repeat (n_drain) send_random(drain_flush_pct);
   endtask

   task automatic quiesce();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [CSR_DATA_W-1:0] val,
                            input bit last_write);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= val;
      @(posedge clock);
      sb.set_reg(idx, val);
      if (last_write) csr_wr_en <= 1'b0;
   endtask

   task automatic set_frame(input logic fmode, input logic rad, input logic [GAIN_W-1:0] g,
                            input int unsigned w, input int unsigned h);
      quiesce();
      csr_write(CSR_FILTER_MODE, CSR_DATA_W'(fmode), 1'b0);
      csr_write(CSR_RADIUS, CSR_DATA_W'(rad), 1'b0);
      csr_write(CSR_GAIN, CSR_DATA_W'(g), 1'b0);
      csr_write(CSR_IMAGE_WIDTH, CSR_DATA_W'(w), 1'b0);
      csr_write(CSR_IMAGE_HEIGHT, CSR_DATA_W'(h), 1'b1);
   endtask

   task automatic random_frames(input int unsigned item_goal);
      int unsigned first_item, w_wr, h_wr;
      first_item = items_sent;
      while (items_sent - first_item < item_goal) begin
         case ($urandom_range(9))
            0:       w_wr = $urandom_range(2);
            1:       w_wr = $urandom_range(24, 10);
            default: w_wr = $urandom_range(9, 3);
         endcase
         h_wr = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(6, 3);
         set_frame(1'($urandom_range(1)), 1'($urandom_range(1)),
                   GAIN_W'($urandom_range(15)), w_wr, h_wr);
         send_frame($urandom_range(10), ($urandom_range(1) == 1) ? 100 : $urandom_range(100));
      end
   endtask

   initial begin : stimulus
      reset            = 1'b1;
      req_bus.valid    = 1'b0;
      req_bus.req_type = REQ_PIXEL;
      req_bus.pixel_in = '0;
      csr_wr_en        = 1'b0;
      csr_index        = CSR_FILTER_MODE;
      csr_wr_data      = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // undersized geometry, top gain, flush as centre, drained by pixels
      set_frame(1'b0, 1'b1, 4'd15, 1, 0);
      send_item(REQ_PIXEL, 8'd0);
      send_item(REQ_PIXEL, 8'd255);
      send_item(REQ_PIXEL, 8'd0);
      send_item(REQ_PIXEL, 8'd255);
      send_item(REQ_FLUSH, 8'd255);
      send_item(REQ_PIXEL, 8'd255);
      send_item(REQ_PIXEL, 8'd0);
      send_item(REQ_PIXEL, 8'd255);
      send_item(REQ_PIXEL, 8'd0);
      send_item(REQ_PIXEL, 8'h5A);
      send_item(REQ_PIXEL, 8'hA5);
      send_item(REQ_PIXEL, 8'd255);
      send_item(REQ_PIXEL, 8'd0);

      // height shrunk mid-frame below the output count: frame ends at once
      set_frame(1'b1, 1'b0, 4'd10, 3, 4096);
      repeat (15) send_item(REQ_PIXEL, some_pixel());
      quiesce();
      csr_write(CSR_IMAGE_HEIGHT, CSR_DATA_W'(3), 1'b1);
      send_item(REQ_FLUSH, 8'hFF);

      random_frames(150);

      src_gap_pct    = 78;
      sink_stall_pct = 25;
      random_frames(150);

      src_gap_pct    = 0;
      sink_stall_pct = 0;
      // output held off while the input keeps coming
      set_frame(1'b0, 1'b1, 4'd2, 16, 4);
      hold_orders <= hold_orders + 1;
      send_frame(5, 100);
      random_frames(150);

      quiesce();
      if (sb.n_errors == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

endmodule
